/* rtl/cantp_pkg.sv */
// Shared types and constants for the CAN transport receive reassembler.
package cantp_pkg;

   localparam int unsigned BufferBytesDefault = 4096;

   localparam int unsigned IdWidth     = 29;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDatWidth = 29;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CsrTargetId    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrFcBlockSize = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrFcSep       = 2'd2;

   localparam logic [7:0] FcSeparationReset = 8'd32;

   // Protocol control info frame types (high nibble of byte0)
   localparam logic [3:0] PciSingle      = 4'h0;
   localparam logic [3:0] PciFirst       = 4'h1;
   localparam logic [3:0] PciConsecutive = 4'h2;

   typedef enum logic [2:0] {
      StatusOtherId     = 3'd0,
      StatusUnsupported = 3'd1,
      StatusSingle      = 3'd2,
      StatusFirst       = 3'd3,
      StatusConsecutive = 3'd4,
      StatusSeqError    = 3'd5,
      StatusStray       = 3'd6
   } status_type;

   typedef struct packed {
      logic [IdWidth-1:0] target_id;
      logic [7:0]         fc_block_size;
      logic [7:0]         fc_separation;
   } cfg_type;

   typedef struct packed {
      logic [IdWidth-1:0] can_id;
      logic [3:0]         dlc;
      logic [7:0]         byte0;
      logic [7:0]         byte1;
      logic [7:0]         byte2;
      logic [7:0]         byte3;
      logic [7:0]         byte4;
      logic [7:0]         byte5;
      logic [7:0]         byte6;
      logic [7:0]         byte7;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [11:0] write_offset;
      logic [2:0]  write_count;
      logic [55:0] payload;
      logic        message_done;
      logic [12:0] message_length;
      logic        send_flow_control;
      logic [7:0]  fc_block;
      logic [7:0]  fc_gap;
   } result_type;

   typedef struct packed {
      logic [12:0] received_count;
      logic [11:0] expected_length;
      logic [3:0]  last_sequence;
      logic        sequence_known;
   } xfer_type;

endpackage

/* rtl/can_transport_rx_reassembler.sv */
// Top level of the CAN transport receive reassembler: channel registers and wiring.
//
// Takes one received CAN frame per cycle while req_stall is low and returns one result
// per frame: the decoded frame type, where the payload bytes belong in the message
// buffer, message completion and any flow-control request. A frame is captured in an
// input register, decoded against the transfer state in one pass, and held in a result
// register, so a new frame can follow every cycle while the result side does not stall.
// A stall on the result side holds the result register and, in the same cycle, the input
// register, which then raises req_stall. csr_ready is always high; write the registers
// only while no frame is in flight.
module can_transport_rx_reassembler #(
   parameter int unsigned BUFFER_BYTES = cantp_pkg::BufferBytesDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cantp_pkg::IdWidth-1:0]       req_can_id,
   input  logic [3:0]                          req_dlc,
   input  logic [7:0]                          req_byte0,
   input  logic [7:0]                          req_byte1,
   input  logic [7:0]                          req_byte2,
   input  logic [7:0]                          req_byte3,
   input  logic [7:0]                          req_byte4,
   input  logic [7:0]                          req_byte5,
   input  logic [7:0]                          req_byte6,
   input  logic [7:0]                          req_byte7,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic [11:0]                         rsp_write_offset,
   output logic [2:0]                          rsp_write_count,
   output logic [55:0]                         rsp_payload,
   output logic                                rsp_message_done,
   output logic [12:0]                         rsp_message_length,
   output logic                                rsp_send_flow_control,
   output logic [7:0]                          rsp_fc_block,
   output logic [7:0]                          rsp_fc_gap,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cantp_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [cantp_pkg::CsrDatWidth-1:0]   csr_data
);
   import cantp_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in, req_item;
   logic       item_valid_ff, item_valid_in;
   result_type rsp_ff, rsp_in, core_result;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       fire;
   logic       req_accept;

   assign req_item = '{can_id: req_can_id, dlc: req_dlc, byte0: req_byte0,
                       byte1: req_byte1, byte2: req_byte2, byte3: req_byte3,
                       byte4: req_byte4, byte5: req_byte5, byte6: req_byte6,
                       byte7: req_byte7};

   // result register frees up when empty or being taken
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign fire       = item_valid_ff && advance;
   assign req_stall  = item_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign item_valid_in = req_accept || req_stall;
   assign item_in       = req_accept ? req_item : item_ff;
   assign rsp_valid_in  = fire || (rsp_valid_ff && rsp_stall);
   assign rsp_in        = fire ? core_result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   cantp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cantp_core #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_ff.status;
   assign rsp_write_offset      = rsp_ff.write_offset;
   assign rsp_write_count       = rsp_ff.write_count;
   assign rsp_payload           = rsp_ff.payload;
   assign rsp_message_done      = rsp_ff.message_done;
   assign rsp_message_length    = rsp_ff.message_length;
   assign rsp_send_flow_control = rsp_ff.send_flow_control;
   assign rsp_fc_block          = rsp_ff.fc_block;
   assign rsp_fc_gap            = rsp_ff.fc_gap;

endmodule

/* rtl/cantp_csr.sv */
// Configuration registers: target identifier and flow-control parameters.
module cantp_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cantp_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [cantp_pkg::CsrDatWidth-1:0]     csr_data,
   output cantp_pkg::cfg_type                    cfg
);
   import cantp_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrTargetId:    cfg_in.target_id     = csr_data[IdWidth-1:0];
            CsrFcBlockSize: cfg_in.fc_block_size = csr_data[7:0];
            CsrFcSep:       cfg_in.fc_separation = csr_data[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_id     <= '0;
         cfg_ff.fc_block_size <= '0;
         cfg_ff.fc_separation <= FcSeparationReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/cantp_core.sv */
// Frame decode, transfer tracking and result formation for one frame.
module cantp_core #(
   parameter int unsigned BUFFER_BYTES = cantp_pkg::BufferBytesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  cantp_pkg::item_type    item,
   input  cantp_pkg::cfg_type     cfg,
   output cantp_pkg::result_type  result
);
   import cantp_pkg::*;

   localparam logic [12:0] BufLimit = 13'(BUFFER_BYTES);

   xfer_type xfer_ff, xfer_in, xfer_next;

   logic [3:0]  len_eff;
   logic [3:0]  frame_kind;
   logic [3:0]  low_nib;
   logic        id_hit;
   logic [11:0] first_len;
   logic [2:0]  sf_n;
   logic [2:0]  ff_raw;
   logic [2:0]  ff_n;
   logic [2:0]  cf_raw;
   logic [12:0] remaining;
   logic [2:0]  cf_n;
   logic [13:0] cf_sum;
   logic [12:0] cf_count_next;
   logic [12:0] room;
   logic [2:0]  cf_fit;
   logic        seq_ok;
   logic        from_byte2;
   logic [7:0]  data [8];
   logic [55:0] packed_bytes;

   assign len_eff    = (item.dlc > 4'd8) ? 4'd8 : item.dlc;
   assign frame_kind = item.byte0[7:4];
   assign low_nib    = item.byte0[3:0];
   assign id_hit     = (item.can_id == cfg.target_id);
   assign first_len  = {low_nib, item.byte1};

   assign sf_n   = (low_nib > 4'd7) ? 3'd7 : low_nib[2:0];
   assign ff_raw = (len_eff >= 4'd2) ? 3'(len_eff - 4'd2) : 3'd0;
   assign ff_n   = ({9'd0, ff_raw} > first_len) ? first_len[2:0] : ff_raw;

   assign cf_raw    = (len_eff >= 4'd1) ? 3'(len_eff - 4'd1) : 3'd0;
   assign remaining = ({1'b0, xfer_ff.expected_length} > xfer_ff.received_count) ?
                      ({1'b0, xfer_ff.expected_length} - xfer_ff.received_count) : 13'd0;
   assign cf_n      = ({10'd0, cf_raw} > remaining) ? remaining[2:0] : cf_raw;
   assign cf_sum    = {1'b0, xfer_ff.received_count} + 14'(cf_n);
   // saturate the running count
   assign cf_count_next = (cf_sum > 14'd8191) ? 13'h1FFF : cf_sum[12:0];

   // truncate writes at the buffer end
   assign room   = BufLimit - xfer_ff.received_count;
   assign cf_fit = (xfer_ff.received_count >= BufLimit) ? 3'd0 :
                   (({10'd0, cf_n} > room) ? room[2:0] : cf_n);

   assign seq_ok = !xfer_ff.sequence_known ||
                   (low_nib == 4'(xfer_ff.last_sequence + 4'd1));

   assign data[0] = item.byte1;
   assign data[1] = item.byte2;
   assign data[2] = item.byte3;
   assign data[3] = item.byte4;
   assign data[4] = item.byte5;
   assign data[5] = item.byte6;
   assign data[6] = item.byte7;
   assign data[7] = 8'd0;

   always_comb begin
      xfer_next  = xfer_ff;
      result     = '0;
      from_byte2 = 1'b0;
      if (id_hit) begin
         case (frame_kind)
            PciSingle: begin
               xfer_next             = '0;
               result.status         = StatusSingle;
               result.write_count    = sf_n;
               result.message_done   = 1'b1;
               result.message_length = {10'd0, sf_n};
            end
            PciFirst: begin
               xfer_next                 = '0;
               xfer_next.expected_length = first_len;
               xfer_next.received_count  = {10'd0, ff_n};
               from_byte2                = 1'b1;
               result.status             = StatusFirst;
               result.write_count        = ff_n;
               result.send_flow_control  = 1'b1;
               result.fc_block           = cfg.fc_block_size;
               result.fc_gap             = cfg.fc_separation;
               if ((first_len != 12'd0) && ({9'd0, ff_n} >= first_len)) begin
                  result.message_done   = 1'b1;
                  result.message_length = {10'd0, ff_n};
                  xfer_next             = '0;
               end
            end
            PciConsecutive: begin
               if (xfer_ff.expected_length == 12'd0) begin
                  result.status = StatusStray;
               end else if (!seq_ok) begin
                  result.status = StatusSeqError;
                  xfer_next     = '0;
               end else begin
                  xfer_next.last_sequence  = low_nib;
                  xfer_next.sequence_known = 1'b1;
                  xfer_next.received_count = cf_count_next;
                  result.status            = StatusConsecutive;
                  result.write_count       = cf_fit;
                  result.write_offset      = (xfer_ff.received_count >= BufLimit) ?
                                             12'd0 : xfer_ff.received_count[11:0];
                  if (cf_count_next >= {1'b0, xfer_ff.expected_length}) begin
                     result.message_done   = 1'b1;
                     result.message_length = cf_count_next;
                     xfer_next             = '0;
                  end
               end
            end
            default: begin
               result.status = StatusUnsupported;
            end
         endcase
      end
      // pack delivered bytes, zero the unused lanes
      for (int i = 0; i < 7; i++) begin
         if (3'(i) < result.write_count) begin
            if (from_byte2) begin
               packed_bytes[8*i +: 8] = data[i+1];
            end else begin
               packed_bytes[8*i +: 8] = data[i];
            end
         end else begin
            packed_bytes[8*i +: 8] = 8'd0;
         end
      end
      result.payload = packed_bytes;
   end

   assign xfer_in = fire ? xfer_next : xfer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xfer_ff <= '0;
      end else begin
         xfer_ff <= xfer_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      xfer_ff.received_count <= {1'b0, xfer_ff.expected_length})
      else $error("received count beyond announced length");

   a_seq_needs_xfer: assert property (@(posedge clock) disable iff (reset)
      xfer_ff.sequence_known |-> (xfer_ff.expected_length != 12'd0))
      else $error("sequence tracked with no transfer open");

   a_done_closes: assert property (@(posedge clock) disable iff (reset)
      (fire && result.message_done) |=> (xfer_ff.expected_length == 12'd0))
      else $error("transfer still open after completion");

   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      result.message_done |-> (result.status == StatusSingle ||
                               result.status == StatusFirst ||
                               result.status == StatusConsecutive))
      else $error("completion flagged on a non-data frame");

endmodule

/* dv/can_transport_rx_checker.sv */
`timescale 1ns / 1ps
// Frame decode predictor and result scoreboard for the CAN transport receive reassembler.
module can_transport_rx_checker #(
   parameter int unsigned BUFFER_BYTES = cantp_pkg::BufferBytesDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [cantp_pkg::IdWidth-1:0]     req_can_id,
   input  logic [3:0]                        req_dlc,
   input  logic [7:0]                        req_byte0,
   input  logic [7:0]                        req_byte1,
   input  logic [7:0]                        req_byte2,
   input  logic [7:0]                        req_byte3,
   input  logic [7:0]                        req_byte4,
   input  logic [7:0]                        req_byte5,
   input  logic [7:0]                        req_byte6,
   input  logic [7:0]                        req_byte7,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [2:0]                        rsp_status,
   input  logic [11:0]                       rsp_write_offset,
   input  logic [2:0]                        rsp_write_count,
   input  logic [55:0]                       rsp_payload,
   input  logic                              rsp_message_done,
   input  logic [12:0]                       rsp_message_length,
   input  logic                              rsp_send_flow_control,
   input  logic [7:0]                        rsp_fc_block,
   input  logic [7:0]                        rsp_fc_gap,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [cantp_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [cantp_pkg::CsrDatWidth-1:0] csr_data,
   output int unsigned                       results_seen,
   output int unsigned                       mismatches
);
   import cantp_pkg::*;

   localparam int unsigned CountMax = 8191;

   cfg_type     cfg;
   xfer_type    xfer;
   result_type  pending_results[$];
   int unsigned seen_cnt = 0;
   int unsigned miss_cnt = 0;

   assign results_seen = seen_cnt;
   assign mismatches   = miss_cnt;

   function automatic int unsigned buffer_room(input int unsigned offset, input int unsigned n);
      if (offset >= BUFFER_BYTES)
         return 0;
      return (n < BUFFER_BYTES - offset) ? n : BUFFER_BYTES - offset;
   endfunction

   // Decode one accepted frame against the transfer state and advance that state.
   function automatic result_type decode_frame(input item_type frame);
      result_type  r;
      logic [7:0]  data [8];
      logic [3:0]  kind;
      logic [3:0]  low;
      logic [3:0]  next_seq;
      int unsigned dlc_eff, n, first, offset, count, remain, total;
      r = '0;
      data = '{frame.byte0, frame.byte1, frame.byte2, frame.byte3,
               frame.byte4, frame.byte5, frame.byte6, frame.byte7};
      kind = frame.byte0[7:4];
      low = frame.byte0[3:0];
      next_seq = xfer.last_sequence + 4'd1;
      dlc_eff = (frame.dlc > 4'd8) ? 8 : frame.dlc;
      first = 1;
      count = 0;
      if (frame.can_id != cfg.target_id) begin
         r.status = StatusOtherId;
      end else if (kind == PciSingle) begin
         // a single frame abandons any open transfer; dlc plays no part
         xfer = '0;
         n = (low > 4'd7) ? 7 : low;
         r.status = StatusSingle;
         count = buffer_room(0, n);
         r.message_done = 1'b1;
         r.message_length = 13'(n);
      end else if (kind == PciFirst) begin
         xfer = '0;
         xfer.expected_length = {low, frame.byte1};
         n = (dlc_eff >= 2) ? dlc_eff - 2 : 0;
         if (n > xfer.expected_length)
            n = xfer.expected_length;
         r.status = StatusFirst;
         first = 2;
         count = buffer_room(0, n);
         xfer.received_count = 13'(n);
         r.send_flow_control = 1'b1;
         r.fc_block = cfg.fc_block_size;
         r.fc_gap = cfg.fc_separation;
      end else if (kind == PciConsecutive) begin
         if (xfer.expected_length == 0) begin
            r.status = StatusStray;
         end else if (xfer.sequence_known && low != next_seq) begin
            r.status = StatusSeqError;
            xfer = '0;
         end else begin
            xfer.last_sequence = low;
            xfer.sequence_known = 1'b1;
            n = (dlc_eff >= 1) ? dlc_eff - 1 : 0;
            remain = (xfer.expected_length > xfer.received_count) ?
                     xfer.expected_length - xfer.received_count : 0;
            if (n > remain)
               n = remain;
            r.status = StatusConsecutive;
            offset = xfer.received_count;
            count = buffer_room(offset, n);
            total = xfer.received_count + n;
            xfer.received_count = (total > CountMax) ? 13'(CountMax) : 13'(total);
            r.write_offset = (offset >= BUFFER_BYTES) ? 12'd0 : 12'(offset);
         end
      end else begin
         r.status = StatusUnsupported;
      end
      if ((r.status == StatusFirst || r.status == StatusConsecutive) &&
          xfer.expected_length != 0 && xfer.received_count >= xfer.expected_length) begin
         r.message_done = 1'b1;
         r.message_length = xfer.received_count;
         xfer = '0;
      end
      r.write_count = 3'(count);
      for (int i = 0; i < 7; i++) begin
         if (i < count)
            r.payload[8*i +: 8] = data[first + i];
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         miss_cnt++;
         if (miss_cnt <= 10)
            $display("result %0d: %s expected 0x%0h, got 0x%0h", seen_cnt, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      item_type   frame;
      result_type got;
      result_type want;
      if (reset) begin
         cfg = '{target_id: '0, fc_block_size: '0, fc_separation: FcSeparationReset};
         xfer = '0;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrTargetId:    cfg.target_id = csr_data[IdWidth-1:0];
               CsrFcBlockSize: cfg.fc_block_size = csr_data[7:0];
               CsrFcSep:       cfg.fc_separation = csr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_write_offset, rsp_write_count, rsp_payload,
                   rsp_message_done, rsp_message_length, rsp_send_flow_control,
                   rsp_fc_block, rsp_fc_gap};
            seen_cnt++;
            if (pending_results.size() == 0) begin
               miss_cnt++;
               if (miss_cnt <= 10)
                  $display("result %0d arrived with no frame outstanding, status %0d",
                           seen_cnt, got.status);
            end else begin
               want = pending_results.pop_front();
               check_field("status", want.status, got.status);
               check_field("write_offset", want.write_offset, got.write_offset);
               check_field("write_count", want.write_count, got.write_count);
               check_field("payload", want.payload, got.payload);
               check_field("message_done", want.message_done, got.message_done);
               check_field("message_length", want.message_length, got.message_length);
               check_field("send_flow_control", want.send_flow_control,
                           got.send_flow_control);
               check_field("fc_block", want.fc_block, got.fc_block);
               check_field("fc_gap", want.fc_gap, got.fc_gap);
            end
         end
         if (req_valid && !req_stall) begin
            frame = {req_can_id, req_dlc, req_byte0, req_byte1, req_byte2, req_byte3,
                     req_byte4, req_byte5, req_byte6, req_byte7};
            pending_results.push_back(decode_frame(frame));
         end
      end
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Stimulus, flow control and verdict for the CAN transport receive reassembler.
module tb_top;
   import cantp_pkg::*;

   localparam int unsigned BufferBytes = BufferBytesDefault;
   localparam int unsigned CycleLimit  = 600000;
   localparam logic [CsrIdxWidth-1:0] CsrSpare = 2'd3;
   // frame types the block does not handle
   localparam logic [3:0] PciFlowControl = 4'h3;
   localparam logic [3:0] PciLastType    = 4'hF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [IdWidth-1:0]     req_can_id = '0;
   logic [3:0]             req_dlc = '0;
   logic [7:0]             req_byte0 = '0, req_byte1 = '0, req_byte2 = '0, req_byte3 = '0;
   logic [7:0]             req_byte4 = '0, req_byte5 = '0, req_byte6 = '0, req_byte7 = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_status;
   logic [11:0]            rsp_write_offset;
   logic [2:0]             rsp_write_count;
   logic [55:0]            rsp_payload;
   logic                   rsp_message_done;
   logic [12:0]            rsp_message_length;
   logic                   rsp_send_flow_control;
   logic [7:0]             rsp_fc_block;
   logic [7:0]             rsp_fc_gap;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrDatWidth-1:0] csr_data = '0;

   logic                   calm = 1'b0;
   logic [IdWidth-1:0]     target = '0;
   int unsigned            stall_left = 0;
   int unsigned            frames_sent = 0;
   int unsigned            frames_counted = 0;
   int unsigned            cycles = 0;
   int unsigned            results_seen;
   int unsigned            mismatches;

   can_transport_rx_reassembler #(.BUFFER_BYTES(BufferBytes)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_can_id(req_can_id),
      .req_dlc(req_dlc), .req_byte0(req_byte0), .req_byte1(req_byte1),
      .req_byte2(req_byte2), .req_byte3(req_byte3), .req_byte4(req_byte4),
      .req_byte5(req_byte5), .req_byte6(req_byte6), .req_byte7(req_byte7),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_write_offset(rsp_write_offset), .rsp_write_count(rsp_write_count),
      .rsp_payload(rsp_payload), .rsp_message_done(rsp_message_done),
      .rsp_message_length(rsp_message_length),
      .rsp_send_flow_control(rsp_send_flow_control), .rsp_fc_block(rsp_fc_block),
      .rsp_fc_gap(rsp_fc_gap),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   can_transport_rx_checker #(.BUFFER_BYTES(BufferBytes)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_can_id(req_can_id),
      .req_dlc(req_dlc), .req_byte0(req_byte0), .req_byte1(req_byte1),
      .req_byte2(req_byte2), .req_byte3(req_byte3), .req_byte4(req_byte4),
      .req_byte5(req_byte5), .req_byte6(req_byte6), .req_byte7(req_byte7),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_write_offset(rsp_write_offset), .rsp_write_count(rsp_write_count),
      .rsp_payload(rsp_payload), .rsp_message_done(rsp_message_done),
      .rsp_message_length(rsp_message_length),
      .rsp_send_flow_control(rsp_send_flow_control), .rsp_fc_block(rsp_fc_block),
      .rsp_fc_gap(rsp_fc_gap),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .results_seen(results_seen), .mismatches(mismatches)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result-side back-pressure: hold each stall decision for a random run of cycles.
   always @(posedge clock) begin : backpressure
      int unsigned pick;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            rsp_stall <= 1'b0;
            stall_left <= $urandom_range(0, 3);
         end else if (pick < 92) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(5, 30);
         end
      end
   end

   function automatic int unsigned idle_gap();
      int unsigned pick;
      if (calm)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [3:0] pick_dlc();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         return 4'd8;
      if (pick < 90)
         return 4'($urandom_range(9, 15));
      return 4'($urandom_range(0, 7));
   endfunction

   function automatic logic [IdWidth-1:0] stranger_id();
      if ($urandom_range(0, 1) == 0)
         return IdWidth'($urandom);
      return target ^ (IdWidth'(1) << $urandom_range(0, IdWidth - 1));
   endfunction

   function automatic item_type make_frame(input logic [IdWidth-1:0] id, input logic [3:0] dlc,
                                           input logic [7:0] ctl);
      item_type f;
      f.can_id = id;
      f.dlc = dlc;
      f.byte0 = ctl;
      f.byte1 = 8'($urandom);
      f.byte2 = 8'($urandom);
      f.byte3 = 8'($urandom);
      f.byte4 = 8'($urandom);
      f.byte5 = 8'($urandom);
      f.byte6 = 8'($urandom);
      f.byte7 = 8'($urandom);
      return f;
   endfunction

   task automatic send_frame(input item_type f);
      int unsigned gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_can_id <= f.can_id;
      req_dlc <= f.dlc;
      req_byte0 <= f.byte0;
      req_byte1 <= f.byte1;
      req_byte2 <= f.byte2;
      req_byte3 <= f.byte3;
      req_byte4 <= f.byte4;
      req_byte5 <= f.byte5;
      req_byte6 <= f.byte6;
      req_byte7 <= f.byte7;
      do @(posedge clock); while (req_stall);
      frames_sent++;
      if (f.can_id == target)
         frames_counted++;
   endtask

   task automatic send_pci(input logic [3:0] kind, input logic [3:0] low, input logic [3:0] dlc);
      send_frame(make_frame(target, dlc, {kind, low}));
   endtask

   task automatic send_first(input logic [11:0] size, input logic [3:0] dlc);
      item_type f;
      f = make_frame(target, dlc, {PciFirst, size[11:8]});
      f.byte1 = size[7:0];
      send_frame(f);
   endtask

   // One segmented message; with faults allowed it may be broken off part way.
   task automatic send_message(input int unsigned size, input logic faults);
      int unsigned got, dlc_eff, fault;
      logic [3:0]  dlc;
      logic [3:0]  seq;
      dlc = pick_dlc();
      send_first(12'(size), dlc);
      dlc_eff = (dlc > 4'd8) ? 8 : dlc;
      got = (dlc_eff >= 2) ? dlc_eff - 2 : 0;
      if (got > size)
         got = size;
      seq = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd1;
      while (got < size) begin
         fault = faults ? $urandom_range(0, 199) : 200;
         if (fault < 2) begin
            send_pci(PciConsecutive, seq + 4'($urandom_range(1, 15)), pick_dlc());
            return;
         end else if (fault < 4) begin
            send_pci(PciSingle, 4'($urandom), pick_dlc());
            return;
         end else if (fault < 7) begin
            send_frame(make_frame(stranger_id(), pick_dlc(), 8'($urandom)));
         end
         dlc = ($urandom_range(0, 19) == 0) ? 4'($urandom) : pick_dlc();
         send_pci(PciConsecutive, seq, dlc);
         seq = seq + 4'd1;
         dlc_eff = (dlc > 4'd8) ? 8 : dlc;
         dlc_eff = (dlc_eff >= 1) ? dlc_eff - 1 : 0;
         got += (dlc_eff < size - got) ? dlc_eff : size - got;
      end
   endtask

   task automatic random_traffic(input int unsigned frames);
      int unsigned goal, pick, size;
      goal = frames_counted + frames;
      while (frames_counted < goal) begin
         calm <= ($urandom_range(0, 9) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            size = $urandom_range(0, 99);
            if (size < 70)
               size = $urandom_range(0, 40);
            else if (size < 95)
               size = $urandom_range(41, 300);
            else
               size = $urandom_range(301, 700);
            send_message(size, 1'b1);
         end else if (pick < 75) begin
            send_pci(PciSingle, 4'($urandom), pick_dlc());
         end else if (pick < 82) begin
            send_frame(make_frame(stranger_id(), 4'($urandom), 8'($urandom)));
         end else if (pick < 88) begin
            send_pci(4'($urandom_range(PciFlowControl, PciLastType)), 4'($urandom), pick_dlc());
         end else if (pick < 93) begin
            send_pci(PciConsecutive, 4'($urandom), pick_dlc());
         end else begin
            // header with an arbitrary length, then a few frames in any order
            send_first(12'($urandom), 4'($urandom));
            repeat ($urandom_range(0, 3))
               send_pci(PciConsecutive, 4'($urandom), pick_dlc());
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (results_seen < frames_sent) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [CsrDatWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic [IdWidth-1:0] id, input logic [7:0] fc_blk,
                             input logic [7:0] separation, input logic with_spare);
      logic [CsrDatWidth-1:0] value;
      drain_results();
      write_reg(CsrTargetId, id);
      // upper data bits are don't-care for the byte-wide registers
      value = CsrDatWidth'($urandom);
      value[7:0] = fc_blk;
      write_reg(CsrFcBlockSize, value);
      value = CsrDatWidth'($urandom);
      value[7:0] = separation;
      write_reg(CsrFcSep, value);
      if (with_spare)
         write_reg(CsrSpare, CsrDatWidth'($urandom));
      csr_valid <= 1'b0;
      target = id;
   endtask

   initial begin
      item_type f;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: target 0, block size 0, separation at its reset code
      send_frame(make_frame(29'h1FFFFFFF, 4'd8, {PciSingle, 4'd2}));
      send_pci(PciFlowControl, 4'hA, 4'd8);
      send_pci(PciLastType, 4'hF, 4'hF);
      send_pci(PciSingle, 4'd0, 4'd1);
      send_pci(PciSingle, 4'd7, 4'd8);
      send_pci(PciSingle, 4'hF, 4'd0);
      send_pci(PciConsecutive, 4'd1, 4'd8);
      send_first(12'd0, 4'd8);
      send_first(12'd5, 4'd8);
      // no bytes in the header, then padding on the last consecutive frame
      send_first(12'd20, 4'd1);
      send_pci(PciConsecutive, 4'hF, 4'd0);
      send_pci(PciConsecutive, 4'h0, 4'd8);
      send_pci(PciConsecutive, 4'h1, 4'hF);
      send_pci(PciConsecutive, 4'h2, 4'd8);
      // longest announced length, broken by a sequence gap
      send_first(12'hFFF, 4'd8);
      send_pci(PciConsecutive, 4'h1, 4'd8);
      send_pci(PciConsecutive, 4'h3, 4'd8);
      send_pci(PciConsecutive, 4'h4, 4'd8);
      // single frame drops an open transfer
      send_first(12'd100, 4'd8);
      send_pci(PciConsecutive, 4'h5, 4'd8);
      send_pci(PciSingle, 4'd3, 4'd4);
      send_pci(PciConsecutive, 4'h6, 4'd8);
      f = make_frame(target, 4'd8, {PciSingle, 4'd7});
      {f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7} = '1;
      send_frame(f);
      f = make_frame(target, 4'd8, {PciSingle, 4'd7});
      {f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6, f.byte7} = '0;
      send_frame(f);

      set_config('0, 8'd0, 8'd0, 1'b0);
      random_traffic(220);
      set_config('1, 8'hFF, 8'hFF, 1'b1);
      calm <= 1'b0;
      send_message(4095, 1'b0);
      random_traffic(80);
      set_config(IdWidth'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      random_traffic(220);
      set_config(IdWidth'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      random_traffic(220);

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && results_seen == frames_sent)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
